@@ rtl/core/bilateral_filter_5x5_assert.svh @@
// assertion macros for the bilateral filter block
// users supply a clock named clk and a reset named rst
`ifndef BILATERAL_FILTER_5X5_ASSERT_SVH
`define BILATERAL_FILTER_5X5_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BF5_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define BF5_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/bf5_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and the range weight table of the bilateral filter
// no dependencies
package bf5_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_WINDOW    = 5;

  localparam int CFG_W   = 11;
  localparam int ROW_W   = 10;
  localparam int COL_W   = 11;
  localparam int PIX_W   = 8;
  localparam int WT_W    = 17;
  localparam int Q_W     = 8;

  localparam int MAX_HEIGHT   = 1024;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTER,
    ST_SCAN,
    ST_FLUSH,
    ST_DSTART,
    ST_DIV,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic clear;
    logic take_center;
    logic acc;
    logic outside;
  } wsum_ctl_t;

  // exp(-floor(d*d/200)) in q1.16, indexed by the absolute difference d;
  // thresholds are the smallest d reaching each table step
  function automatic logic [WT_W-1:0] range_weight(input logic [PIX_W-1:0] d);
    logic [WT_W-1:0] w;
    begin
      if (d < 8'd15)      w = 17'd65536;
      else if (d < 8'd20) w = 17'd24109;
      else if (d < 8'd25) w = 17'd8869;
      else if (d < 8'd29) w = 17'd3263;
      else if (d < 8'd32) w = 17'd1200;
      else if (d < 8'd35) w = 17'd442;
      else if (d < 8'd38) w = 17'd162;
      else if (d < 8'd40) w = 17'd60;
      else if (d < 8'd43) w = 17'd22;
      else if (d < 8'd45) w = 17'd8;
      else if (d < 8'd47) w = 17'd3;
      else if (d < 8'd49) w = 17'd1;
      else                w = 17'd0;
      return w;
    end
  endfunction

endpackage

@@ rtl/core/bf5_ram.sv @@
`timescale 1ns / 1ps
// generic single-port ram with registered read
// no dependencies
module bf5_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/core/bf5_wsum.sv @@
`timescale 1ns / 1ps
// weight lookup and running sums of weights and weighted pixels
// depends on bf5_pkg
module bf5_wsum import bf5_pkg::*; #(
  parameter int SUMW_W = 22,
  parameter int SWF_W  = 30
) (
  input  logic              clk,
  input  wsum_ctl_t         ctl,
  input  logic [PIX_W-1:0]  rdata,
  output logic [SUMW_W-1:0] sw,
  output logic [SWF_W-1:0]  swf
);

  logic [PIX_W-1:0]      center;
  logic [PIX_W-1:0]      f;
  logic [PIX_W-1:0]      d;
  logic [WT_W-1:0]       w;
  logic [WT_W+PIX_W-1:0] prod;

  always_comb begin
    f    = ctl.outside ? '0 : rdata;
    d    = (center > f) ? (center - f) : (f - center);
    w    = range_weight(d);
    prod = w * f;
  end

  always_ff @(posedge clk) begin
    if (ctl.take_center) begin
      center <= rdata;
    end
    if (ctl.clear) begin
      sw  <= '0;
      swf <= '0;
    end else if (ctl.acc) begin
      sw  <= sw + SUMW_W'(w);
      swf <= swf + SWF_W'(prod);
    end
  end

endmodule

@@ rtl/core/bf5_div.sv @@
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
// depends on bf5_pkg
module bf5_div import bf5_pkg::*; #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 22
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [Q_W-1:0]   q
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] dsh;
  logic [CNT_W-1:0] cnt;
  logic             ge;

  assign busy = (cnt != '0);
  assign ge   = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(Q_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= NUM_W'(den) << (Q_W - 1);
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      dsh <= dsh >> 1;
      q   <= {q[Q_W-2:0], ge};
    end
  end

endmodule

@@ rtl/core/bilateral_filter_5x5.sv @@
`timescale 1ns / 1ps
// top level of the streaming bilateral filter: sequencer, line store, sums, divider
// depends on bf5_pkg, bf5_ram, bf5_wsum, bf5_div and bilateral_filter_5x5_assert.svh
//
//  channel | signals                                   | dir
//  in      | in_valid in_ready cmd pixel               | beat in
//  out     | out_valid out_ready value out_row out_col | beat out
//          |   last frame_done                         |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | beat in
//
// an item that yields no result leaves the sequencer idle; each result takes a
// center read, then one neighbor read per cycle on the single line store port,
// then a divider run before the push step.
// a pixel ending a row yields up to WINDOW/2+1 results, a drain beat one.
// no clearing pass after reset: entries used are always written earlier in the frame, out of frame reads count as zero.
// a full output register stalls the sequencer in its push step only.
module bilateral_filter_5x5 import bf5_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int WINDOW    = DEF_WINDOW
) (
  input  logic             clk,
  input  logic             rst,
  // input beats
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             cmd,
  input  logic [PIX_W-1:0] pixel,
  // result beats
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] value,
  output logic [ROW_W-1:0] out_row,
  output logic [9:0]       out_col,
  output logic             last,
  output logic             frame_done,
  // register writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int RAD    = WINDOW / 2;
  localparam int DEPTH  = WINDOW * MAX_WIDTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int SUMW_W = $clog2(WINDOW * WINDOW * 65536 + 1);
  localparam int SWF_W  = SUMW_W + PIX_W;
  localparam int RST_W  = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

  // slot of a row n rows back, n below WINDOW
  function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] s,
                                                  input int n);
    int t;
    begin
      t = int'(s) + WINDOW - n;
      if (t >= WINDOW) t = t - WINDOW;
      return SLOT_W'(t);
    end
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(WINDOW - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [SLOT_W-1:0] s,
                                            input logic [COL_W-1:0] c);
    return AW'(s) * AW'(MAX_WIDTH) + AW'(c);
  endfunction

  state_t state, state_next;

  // frame geometry
  logic [CFG_W-1:0] frame_width, frame_height;
  logic [CFG_W-1:0] cfg_v;

  // input position and drain position
  logic [ROW_W-1:0]  in_row, drain_row;
  logic [COL_W-1:0]  in_col, drain_col;
  logic [SLOT_W-1:0] in_slot, drain_slot;
  logic              draining;

  // output pixel under work
  logic [ROW_W-1:0]  job_row;
  logic [COL_W-1:0]  job_col, job_last_col;
  logic [SLOT_W-1:0] job_slot;
  logic              job_drain_done;

  // neighbor scan
  logic [SLOT_W-1:0] nb_r, nb_c, nb_slot;
  logic              nb_pend, nb_out;
  logic [11:0]       nrow;
  logic [12:0]       ncol;
  logic              outside;
  logic              scan_end;

  logic cfg_fire, in_fire, pix_take, drain_take, job_start, push_ok, job_end;

  // pixel item plan
  logic             row_end, frame_end, emit_ok;
  logic [COL_W-1:0] first_col;
  logic             drain_done;
  logic [ROW_W-1:0] drain_start;
  int               drain_back;

  // line store
  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [PIX_W-1:0] ram_rdata;

  wsum_ctl_t         wctl;
  logic [SUMW_W-1:0] sw;
  logic [SWF_W-1:0]  swf;
  logic              div_busy;
  logic [Q_W-1:0]    div_q;

  // handshakes: nothing is taken while a result is in flight,
  // and a pending register write holds off input beats
  assign in_ready   = (state == ST_IDLE) && !cfg_valid;
  assign cfg_ready  = (state == ST_IDLE);
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign in_fire    = in_valid && in_ready;
  assign pix_take   = in_fire && (cmd == CMD_PIXEL) && !draining;
  assign drain_take = in_fire && (cmd == CMD_DRAIN) && draining;
  assign push_ok    = !out_valid || out_ready;
  assign job_end    = (job_col == job_last_col);

  // register write value: zero acts as one
  assign cfg_v = (cfg_data == '0) ? CFG_W'(1) : cfg_data;

  // where the incoming pixel sits and which outputs it releases
  always_comb begin
    row_end   = (in_col + 1'b1) >= frame_width;
    frame_end = (CFG_W'(in_row) + 1'b1) >= frame_height;
    emit_ok   = (in_row >= ROW_W'(RAD)) && (row_end || (in_col >= COL_W'(RAD)));
    if (in_col >= COL_W'(RAD)) first_col = in_col - COL_W'(RAD);
    else                       first_col = '0;
    job_start = pix_take ? emit_ok : drain_take;
    drain_done = (CFG_W'(drain_row) == frame_height - 1'b1) &&
                 (drain_col == frame_width - 1'b1);
    // drain covers the final RAD rows, or the whole frame if it is shorter
    if (frame_height > CFG_W'(RAD)) begin
      drain_start = ROW_W'(frame_height - CFG_W'(RAD));
      drain_back  = RAD - 1;
    end else begin
      drain_start = '0;
      drain_back  = int'(frame_height) - 1;
    end
  end

  // neighbor coordinates; out of frame reads as zero
  always_comb begin
    nrow     = 12'(job_row) - 12'(RAD) + 12'(nb_r);
    ncol     = 13'(job_col) - 13'(RAD) + 13'(nb_c);
    outside  = nrow[11] || (nrow[10:0] >= frame_height) ||
               ncol[12] || (ncol[11:0] >= 12'(frame_width));
    scan_end = (nb_r == SLOT_W'(WINDOW - 1)) && (nb_c == SLOT_W'(WINDOW - 1));
  end

  // line store port: writes on pixel beats, center then neighbor reads per result
  always_comb begin
    ram_we = pix_take;
    case (state)
      ST_CENTER: ram_addr = addr_of(job_slot, job_col);
      ST_SCAN:   ram_addr = addr_of(nb_slot, ncol[COL_W-1:0]);
      default:   ram_addr = addr_of(in_slot, in_col);
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (job_start) state_next = ST_CENTER;
      ST_CENTER: state_next = ST_SCAN;
      ST_SCAN:   if (scan_end) state_next = ST_FLUSH;
      ST_FLUSH:  state_next = ST_DSTART;
      ST_DSTART: state_next = ST_DIV;
      ST_DIV:    if (!div_busy) state_next = ST_PUSH;
      ST_PUSH: begin
        if (push_ok) state_next = job_end ? ST_IDLE : ST_CENTER;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    wctl.clear       = (state == ST_CENTER);
    wctl.take_center = (state == ST_SCAN) && (nb_r == '0) && (nb_c == '0);
    wctl.acc         = nb_pend;
    wctl.outside     = nb_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      frame_width  <= CFG_W'(RST_W);
      frame_height <= CFG_W'(RESET_HEIGHT);
      in_row       <= '0;
      in_col       <= '0;
      in_slot      <= '0;
      draining     <= 1'b0;
      drain_row    <= '0;
      drain_col    <= '0;
      drain_slot   <= '0;
      nb_r         <= '0;
      nb_c         <= '0;
      nb_slot      <= '0;
      nb_pend      <= 1'b0;
      nb_out       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state   <= state_next;
      nb_pend <= (state == ST_SCAN);
      nb_out  <= outside;

      if (cfg_fire) begin
        case (cfg_index)
          REG_FRAME_WIDTH: begin
            if (int'(cfg_v) > MAX_WIDTH) frame_width <= CFG_W'(MAX_WIDTH);
            else                         frame_width <= cfg_v;
          end
          REG_FRAME_HEIGHT: begin
            if (int'(cfg_v) > MAX_HEIGHT) frame_height <= CFG_W'(MAX_HEIGHT);
            else                          frame_height <= cfg_v;
          end
          default: ;
        endcase
        // any write restarts the frame
        in_row   <= '0;
        in_col   <= '0;
        in_slot  <= '0;
        draining <= 1'b0;
      end else if (pix_take) begin
        if (row_end) begin
          in_col <= '0;
          if (frame_end) begin
            in_row     <= '0;
            in_slot    <= '0;
            draining   <= 1'b1;
            drain_row  <= drain_start;
            drain_col  <= '0;
            drain_slot <= slot_back(in_slot, drain_back);
          end else begin
            in_row  <= in_row + 1'b1;
            in_slot <= slot_inc(in_slot);
          end
        end else begin
          in_col <= in_col + 1'b1;
        end
      end else if (drain_take) begin
        if (drain_done) begin
          draining <= 1'b0;
        end else if ((drain_col + 1'b1) >= frame_width) begin
          drain_col  <= '0;
          drain_row  <= drain_row + 1'b1;
          drain_slot <= slot_inc(drain_slot);
        end else begin
          drain_col <= drain_col + 1'b1;
        end
      end

      // walk the window row by row
      if (state == ST_CENTER) begin
        nb_r    <= '0;
        nb_c    <= '0;
        nb_slot <= slot_back(job_slot, RAD);
      end else if (state == ST_SCAN) begin
        if (nb_c == SLOT_W'(WINDOW - 1)) begin
          nb_c    <= '0;
          nb_r    <= nb_r + 1'b1;
          nb_slot <= slot_inc(nb_slot);
        end else begin
          nb_c <= nb_c + 1'b1;
        end
      end

      // a new result replaces the one leaving in the same cycle
      if ((state == ST_PUSH) && push_ok) out_valid <= 1'b1;
      else if (out_ready)                out_valid <= 1'b0;
    end
  end

  // job and result payload
  always_ff @(posedge clk) begin
    if (pix_take && emit_ok) begin
      job_row        <= in_row - ROW_W'(RAD);
      job_col        <= row_end ? first_col : in_col - COL_W'(RAD);
      job_last_col   <= row_end ? in_col : in_col - COL_W'(RAD);
      job_slot       <= slot_back(in_slot, RAD);
      job_drain_done <= 1'b0;
    end else if (drain_take) begin
      job_row        <= drain_row;
      job_col        <= drain_col;
      job_last_col   <= drain_col;
      job_slot       <= drain_slot;
      job_drain_done <= drain_done;
    end else if ((state == ST_PUSH) && push_ok && !job_end) begin
      job_col <= job_col + 1'b1;
    end

    if ((state == ST_PUSH) && push_ok) begin
      value      <= div_q;
      out_row    <= job_row;
      out_col    <= job_col[9:0];
      last       <= job_end;
      frame_done <= job_drain_done && job_end;
    end
  end

  bf5_ram #(
    .WIDTH(PIX_W),
    .DEPTH(DEPTH)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(pixel),
    .rdata(ram_rdata)
  );

  bf5_wsum #(
    .SUMW_W(SUMW_W),
    .SWF_W (SWF_W)
  ) u_wsum (
    .clk  (clk),
    .ctl  (wctl),
    .rdata(ram_rdata),
    .sw   (sw),
    .swf  (swf)
  );

  bf5_div #(
    .NUM_W(SWF_W),
    .DEN_W(SUMW_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(state == ST_DSTART),
    .num  (swf),
    .den  (sw),
    .busy (div_busy),
    .q    (div_q)
  );

`include "bilateral_filter_5x5_assert.svh"

  // center weight keeps the divisor nonzero
  `BF5_ASSERT_IMP(a_div_nonzero, state == ST_DSTART, sw != '0, "zero weight sum")
  // divider result is complete before it is pushed
  `BF5_ASSERT_IMP(a_div_ready, state == ST_PUSH, !div_busy, "push while dividing")
  // frame end only on the final result of a beat
  `BF5_ASSERT_IMP(a_done_last, out_valid && frame_done, last, "frame_done without last")

endmodule
